>>> hdl/ukst_pkg.sv
// Package for the unique-key stack: operation and status codes, field widths
// and the control group handed to every stack cell.
// No dependencies.
package ukst_pkg;

  localparam int FUNC_W  = 2;
  localparam int FIELD_W = 32;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd3;

  // Per-cycle control broadcast along the cell chain
  typedef struct packed {
    logic push;   // take the entry of the cell above
    logic pop;    // take the entry of the cell below
    logic cmp;    // register the key match against the incoming request
  } cell_ctrl_t;

endpackage

>>> hdl/unique_key_stack.sv
// Top level of the unique-key stack: request and result channels, the cell
// chain and the result register. Depends on ukst_pkg and ukst_cell.
//
// A last-in first-out stack of key/data pairs that refuses to push a key it
// already holds. Every request (push, pop, peek, query) yields exactly one
// result carrying a status, the removed or top entry (zero otherwise), the
// depth after the operation and an empty flag. Entries live in a chain of
// STACK_DEPTH cells with the top of stack in cell 0; a push shifts every
// entry one cell down, a pop shifts every entry one cell up. In the cycle a
// request is accepted every cell compares its key with the request key and
// registers a match flag; in the execute state that follows the match
// flags are ORed, the operation is decided and the chain shifts. No new
// request is taken while the block is in the execute state, which waits
// while the result register still holds an untaken result. A new request
// is taken while a finished result waits downstream. Keys are compared in
// their low WORD_BITS bits. No clearing pass is needed after reset.
module unique_key_stack import ukst_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int WORD_BITS   = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FUNC_W-1:0]          func,
  input  logic signed [FIELD_W-1:0]  key,
  input  logic signed [FIELD_W-1:0]  value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STAT_W-1:0]          status,
  output logic signed [FIELD_W-1:0]  out_key,
  output logic signed [FIELD_W-1:0]  out_value,
  output logic [DEPTH_W-1:0]         depth,
  output logic                       empty_res
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state;
  logic                 state_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  // held request
  logic [FUNC_W-1:0]    req_func;
  logic [WORD_BITS-1:0] req_key;
  logic [WORD_BITS-1:0] req_value;

  logic                 in_accept;
  logic                 out_free;
  logic                 exec_go;
  logic                 hit_any;
  logic                 full;
  logic                 is_empty;
  logic [WORD_BITS-1:0] key_word;
  logic [WORD_BITS-1:0] value_word;

  cell_ctrl_t           ctrl;

  logic [WORD_BITS-1:0] cell_key   [STACK_DEPTH];
  logic [WORD_BITS-1:0] cell_value [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] cell_occ;
  logic [STACK_DEPTH-1:0] cell_hit;

  // result register next values
  logic [STAT_W-1:0]    status_next;
  logic [FIELD_W-1:0]   out_key_next;
  logic [FIELD_W-1:0]   out_value_next;

  assign in_stall  = (state == ST_EXEC);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign exec_go   = (state == ST_EXEC) && out_free;

  // Keep words in their low WORD_BITS bits, zero above the field
  assign key_word   = WORD_BITS'($unsigned(key));
  assign value_word = WORD_BITS'($unsigned(value));

  assign hit_any  = |cell_hit;
  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign is_empty = (count == '0);

  // Decide the operation in the execute cycle
  always_comb begin
    ctrl           = '0;
    ctrl.cmp       = in_accept;
    count_next     = count;
    status_next    = STAT_OK;
    out_key_next   = '0;
    out_value_next = '0;
    case (req_func)
      FUNC_PUSH: begin
        if (hit_any) begin
          status_next = STAT_DUPLICATE;
        end else if (full) begin
          status_next = STAT_OVERFLOW;
        end else begin
          ctrl.push  = exec_go;
          count_next = count + CNT_W'(1);
        end
      end
      FUNC_POP: begin
        if (is_empty) begin
          status_next = STAT_UNDERFLOW;
        end else begin
          ctrl.pop       = exec_go;
          count_next     = count - CNT_W'(1);
          out_key_next   = FIELD_W'(cell_key[0]);
          out_value_next = FIELD_W'(cell_value[0]);
        end
      end
      FUNC_PEEK: begin
        if (is_empty) begin
          status_next = STAT_UNDERFLOW;
        end else begin
          out_key_next   = FIELD_W'(cell_key[0]);
          out_value_next = FIELD_W'(cell_value[0]);
        end
      end
      default: begin
        // query: report depth only
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the request; payload registers need no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_func  <= func;
      req_key   <= key_word;
      req_value <= value_word;
    end
  end

  // Load the result register when the execute cycle completes
  always_ff @(posedge clk) begin
    if (exec_go) begin
      status    <= status_next;
      out_key   <= out_key_next;
      out_value <= out_value_next;
      depth     <= DEPTH_W'(count_next);
      empty_res <= (count_next == '0);
    end
  end

  // Cell chain: cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] up_key;
    logic [WORD_BITS-1:0] up_value;
    logic                 up_occ;
    logic [WORD_BITS-1:0] lo_key;
    logic [WORD_BITS-1:0] lo_value;
    logic                 lo_occ;

    if (i == 0) begin : g_top
      assign up_key   = req_key;
      assign up_value = req_value;
      assign up_occ   = 1'b1;
    end else begin : g_mid_up
      assign up_key   = cell_key[i-1];
      assign up_value = cell_value[i-1];
      assign up_occ   = cell_occ[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign lo_key   = '0;
      assign lo_value = '0;
      assign lo_occ   = 1'b0;
    end else begin : g_mid_lo
      assign lo_key   = cell_key[i+1];
      assign lo_value = cell_value[i+1];
      assign lo_occ   = cell_occ[i+1];
    end

    ukst_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .cmp_key     (key_word),
      .upper_key   (up_key),
      .upper_value (up_value),
      .upper_occ   (up_occ),
      .lower_key   (lo_key),
      .lower_value (lo_value),
      .lower_occ   (lo_occ),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .occ         (cell_occ[i]),
      .hit         (cell_hit[i])
    );
  end

  // Occupied cells always match the fill count
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_occ) == count)
    else $error("cell occupancy disagrees with fill count");

  // Occupied cells form an unbroken run from the top
  a_occ_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_occ + STACK_DEPTH'(1)) & cell_occ) == '0)
    else $error("gap in occupied cells");

  // Fill count never passes the capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("fill count beyond capacity");

  // A successful push grows the stack by one entry
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (exec_go && (req_func == FUNC_PUSH) && !hit_any && !full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("push did not advance fill count");

  // A match flag never stands on an empty cell after a compare
  a_hit_occ: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> ((cell_hit & ~cell_occ) == '0))
    else $error("match flag on an empty cell");

endmodule

>>> hdl/ukst_cell.sv
// One stack cell: holds a key, a data word, an occupied flag and a match flag.
// Depends on ukst_pkg for the control group type.
module ukst_cell import ukst_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] cmp_key,
  input  logic [WORD_BITS-1:0] upper_key,
  input  logic [WORD_BITS-1:0] upper_value,
  input  logic                 upper_occ,
  input  logic [WORD_BITS-1:0] lower_key,
  input  logic [WORD_BITS-1:0] lower_value,
  input  logic                 lower_occ,
  output logic [WORD_BITS-1:0] key,
  output logic [WORD_BITS-1:0] value,
  output logic                 occ,
  output logic                 hit
);

  // Payload: shift down on push, up on pop, otherwise hold
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      key   <= upper_key;
      value <= upper_value;
    end else if (ctrl.pop) begin
      key   <= lower_key;
      value <= lower_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      hit <= 1'b0;
    end else begin
      if (ctrl.push) begin
        occ <= upper_occ;
      end else if (ctrl.pop) begin
        occ <= lower_occ;
      end
      if (ctrl.cmp) begin
        hit <= occ && (key == cmp_key);
      end
    end
  end

endmodule

>>> tb/tb_unique_key_stack.sv
// Testbench for unique_key_stack: directed table, then random push/pop/peek/query
// traffic checked against an in-bench stack predictor. Depends on ukst_pkg and
// the unique_key_stack RTL only.
module tb_unique_key_stack;
  import ukst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH  = 16;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_PHASES   = 5;
  localparam int PHASE_ITEMS  = 225;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_SIZE    = 24;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] okey;
    logic [FIELD_W-1:0] oval;
    logic [DEPTH_W-1:0] depth;
    logic               empty;
  } stack_result_t;

  // One row of the directed table; fixed rows carry a hand-written result
  typedef struct packed {
    logic [FUNC_W-1:0]  op;
    logic [FIELD_W-1:0] k;
    logic [FIELD_W-1:0] v;
    logic               fixed;
    stack_result_t      want;
  } directed_row_t;

  localparam stack_result_t FROM_PREDICTOR = '0;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [FUNC_W-1:0]         func;
  logic signed [FIELD_W-1:0] key;
  logic signed [FIELD_W-1:0] value;
  logic                      out_valid;
  logic                      out_stall;
  logic [STAT_W-1:0]         status;
  logic signed [FIELD_W-1:0] out_key;
  logic signed [FIELD_W-1:0] out_value;
  logic [DEPTH_W-1:0]        depth;
  logic                      empty_res;

  unique_key_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .WORD_BITS  (FIELD_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .key      (key),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .out_key  (out_key),
    .out_value(out_value),
    .depth    (depth),
    .empty_res(empty_res)
  );

  // Predictor state: index 0 is the bottom of the stack
  logic [FIELD_W-1:0] held_keys [STACK_DEPTH];
  logic [FIELD_W-1:0] held_vals [STACK_DEPTH];
  int                 held_count = 0;

  stack_result_t      pending_results[$];
  int                 errors = 0;
  int                 cycle_count = 0;

  // Idling percentages for the current phase, read by the driver and the
  // result-side stall process
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  // Long hold-off on the result side: bump the ticket to request one
  int                 hold_ticket = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;

  logic [FIELD_W-1:0] key_pool [POOL_SIZE];

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // empty stack: pop and peek underflow, query reports empty
    '{FUNC_POP,   32'h0, 32'h0, 1'b1, '{STAT_UNDERFLOW, 32'h0, 32'h0, 5'd0, 1'b1}},
    '{FUNC_PEEK,  32'h0, 32'h0, 1'b1, '{STAT_UNDERFLOW, 32'h0, 32'h0, 5'd0, 1'b1}},
    '{FUNC_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{STAT_OK, 32'h0, 32'h0, 5'd0, 1'b1}},
    // extremes of key and value, then a refused repeat of the same key
    '{FUNC_PUSH,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
      '{STAT_OK, 32'h0, 32'h0, 5'd1, 1'b0}},
    '{FUNC_PUSH,  32'h8000_0000, 32'h0, 1'b1,
      '{STAT_DUPLICATE, 32'h0, 32'h0, 5'd1, 1'b0}},
    '{FUNC_PEEK,  32'h0, 32'h0, 1'b1,
      '{STAT_OK, 32'h8000_0000, 32'h7FFF_FFFF, 5'd1, 1'b0}},
    '{FUNC_PUSH,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
      '{STAT_OK, 32'h0, 32'h0, 5'd2, 1'b0}},
    '{FUNC_PUSH,  32'h0, 32'hFFFF_FFFF, 1'b1, '{STAT_OK, 32'h0, 32'h0, 5'd3, 1'b0}},
    '{FUNC_PUSH,  32'hFFFF_FFFF, 32'h0, 1'b1, '{STAT_OK, 32'h0, 32'h0, 5'd4, 1'b0}},
    // fill to the top
    '{FUNC_PUSH,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'h0000_0001, 32'hFFFF_FFFE, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'h8000_0001, 32'h7FFF_FFFE, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'h7FFF_FFFE, 32'h8000_0001, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'hFFFF_FFFE, 32'h0000_0001, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'h1234_5678, 32'hEDCB_A987, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'hEDCB_A987, 32'h1234_5678, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'h0000_FFFF, 32'hFFFF_0000, 1'b0, FROM_PREDICTOR},
    '{FUNC_PUSH,  32'hFFFF_0000, 32'h0000_FFFF, 1'b0, FROM_PREDICTOR},
    // full stack: a new key overflows, a held key is refused as duplicate first
    '{FUNC_PUSH,  32'h0000_0002, 32'h0, 1'b1,
      '{STAT_OVERFLOW, 32'h0, 32'h0, 5'd16, 1'b0}},
    '{FUNC_PUSH,  32'h8000_0000, 32'h0, 1'b1,
      '{STAT_DUPLICATE, 32'h0, 32'h0, 5'd16, 1'b0}},
    '{FUNC_QUERY, 32'h0, 32'h0, 1'b1, '{STAT_OK, 32'h0, 32'h0, 5'd16, 1'b0}},
    // pop hands back the entry it removes
    '{FUNC_POP,   32'h0, 32'h0, 1'b1,
      '{STAT_OK, 32'hFFFF_0000, 32'h0000_FFFF, 5'd15, 1'b0}}
  };

  // Work out the result of one request and advance the predictor's stack
  function automatic stack_result_t predict_stack_op(input logic [FUNC_W-1:0] op,
                                                     input logic [FIELD_W-1:0] k,
                                                     input logic [FIELD_W-1:0] v);
    stack_result_t r;
    bit            held;
    r = '0;
    held = 1'b0;
    case (op)
      FUNC_PUSH: begin
        for (int i = 0; i < held_count; i++)
          if (held_keys[i] == k) held = 1'b1;
        // the duplicate check wins over the full check
        if (held) begin
          r.status = STAT_DUPLICATE;
        end else if (held_count >= STACK_DEPTH) begin
          r.status = STAT_OVERFLOW;
        end else begin
          held_keys[held_count] = k;
          held_vals[held_count] = v;
          held_count++;
        end
      end
      FUNC_POP: begin
        if (held_count == 0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          held_count--;
          r.okey = held_keys[held_count];
          r.oval = held_vals[held_count];
        end
      end
      FUNC_PEEK: begin
        if (held_count == 0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.okey = held_keys[held_count-1];
          r.oval = held_vals[held_count-1];
        end
      end
      default: ;
    endcase
    r.depth = DEPTH_W'(held_count);
    r.empty = (held_count == 0);
    return r;
  endfunction

  // Clock: 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if the drain never completes
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Offer one request at the falling edge, after any sender idling, and hold
  // it until the block takes it. Record its expected result on acceptance.
  task automatic send_request(input logic [FUNC_W-1:0] op, input logic [FIELD_W-1:0] k,
                              input logic [FIELD_W-1:0] v, input logic fixed,
                              input stack_result_t typed_result);
    stack_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      func     <= FUNC_W'($urandom);
      key      <= $urandom;
      value    <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_stack_op(op, k, v);
    pending_results.push_back(fixed ? typed_result : predicted);
  endtask

  // Build one random request. Keys come mostly from a small pool or from the
  // stack itself so duplicates are common; push weight follows a fill/drain
  // sweep so the depth roams between empty and full.
  task automatic send_random_request(input int push_pct);
    logic [FUNC_W-1:0]  op;
    logic [FIELD_W-1:0] k;
    int                 roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      op = FUNC_PUSH;
    end else begin
      roll = $urandom_range(99);
      if (roll < 55)      op = FUNC_POP;
      else if (roll < 80) op = FUNC_PEEK;
      else                op = FUNC_QUERY;
    end
    roll = $urandom_range(9);
    if (roll < 2 && held_count > 0) k = held_keys[$urandom_range(held_count-1)];
    else if (roll < 6)             k = key_pool[$urandom_range(POOL_SIZE-1)];
    else                           k = $urandom;
    send_request(op, k, $urandom, 1'b0, FROM_PREDICTOR);
  endtask

  // Result side: stall at random, or hold off for a long stretch on request
  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest outstanding expectation
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d key %h",
                 $time, status, out_key);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", FIELD_W'(want.status), FIELD_W'(status));
        check_field("out_key", want.okey, out_key);
        check_field("out_value", want.oval, out_value);
        check_field("depth", FIELD_W'(want.depth), FIELD_W'(depth));
        check_field("empty_res", FIELD_W'(want.empty), FIELD_W'(empty_res));
      end
    end
  end

  initial begin
    static int idle_pcts  [NUM_PHASES] = '{0, 88, 0, 14, 0};
    static int stall_pcts [NUM_PHASES] = '{0, 0, 88, 14, 0};
    int push_pct;
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = FUNC_QUERY;
    key       = '0;
    value     = '0;
    out_stall = 1'b0;

    // Hold reset, then release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: extremes, every operation and the corner statuses
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_request(directed_rows[i].op, directed_rows[i].k, directed_rows[i].v,
                   directed_rows[i].fixed, directed_rows[i].want);

    // Key pool for the random part, with the extremes kept in it
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hFFFF_FFFF;

    // Random phases: each sets its own idling mix. The first one also holds
    // the result side off for a long stretch while requests keep coming, so
    // the block backs up and stalls its request channel.
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      if (p == 0) hold_ticket++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate fill and drain sweeps every 40 requests
        push_pct = ((n / 40) % 2 == 0) ? 75 : 25;
        send_random_request(push_pct);
      end
    end

    // Drop valid, wait for every outstanding result, then watch for strays
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ukst_pkg.sv
hdl/ukst_cell.sv
hdl/unique_key_stack.sv
tb/tb_unique_key_stack.sv
